// ===== hdl/longest_run_with_k_flips_unit_defines.svh =====
// Assertion macros for the longest-run unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef LONGEST_RUN_WITH_K_FLIPS_UNIT_DEFINES_SVH
`define LONGEST_RUN_WITH_K_FLIPS_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define LRKF_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("lrkf assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define LRKF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lrkf assertion failed");

`endif

// ===== hdl/lrkf_pkg.sv =====
// Shared widths, constants and types for the longest-run unit.
// No dependencies; used by lrkf_track and the top level.
package lrkf_pkg;

	localparam int POS_W        = 20;
	localparam int LEN_W        = POS_W + 1;
	localparam int CFG_W        = 11;
	localparam int CHANGE_LIMIT = 1024;
	localparam int RING_DEPTH   = CHANGE_LIMIT + 1;
	localparam int IDX_W        = $clog2(RING_DEPTH);
	localparam int CNT_W        = $clog2(CHANGE_LIMIT + 1);
	localparam int IN_W         = 8;
	localparam int OUT_W        = ((LEN_W + 7) / 8) * 8;

	// Longest string kept, in symbols
	localparam logic [LEN_W-1:0] MAX_SYMBOLS = LEN_W'(1) << POS_W;

	// Command to one target tracker for one symbol
	typedef struct packed {
		logic             push;
		logic             opp;
		logic             clr;
		logic [CNT_W-1:0] limit;
		logic [POS_W-1:0] pos;
	} trk_cmd_t;

endpackage

// ===== hdl/lrkf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrkf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/lrkf_track.sv =====
// Sliding-window tracker for one target letter: ring of opposite positions.
// Depends on lrkf_pkg and lrkf_ram.
module lrkf_track (
	input  logic                     clk,
	input  logic                     arst_n,
	input  lrkf_pkg::trk_cmd_t       cmd,
	output logic [lrkf_pkg::LEN_W-1:0] win_len
);

	logic [lrkf_pkg::IDX_W-1:0] head_q;
	logic [lrkf_pkg::CNT_W-1:0] count_q;
	logic [lrkf_pkg::LEN_W-1:0] start_q;
	logic [lrkf_pkg::POS_W-1:0] head_val_q;
	logic                       hv_ram_q;

	logic [lrkf_pkg::IDX_W:0]   slot_sum;
	logic [lrkf_pkg::IDX_W-1:0] slot;
	logic [lrkf_pkg::IDX_W-1:0] head_inc;
	logic [lrkf_pkg::POS_W-1:0] rdata;
	logic [lrkf_pkg::POS_W-1:0] eff_head;
	logic [lrkf_pkg::POS_W-1:0] pop_val;
	logic [lrkf_pkg::LEN_W-1:0] start_d;
	logic                       do_push;
	logic                       pop;

	// ring index arithmetic, modulo ring depth
	always_comb begin
		slot_sum = {1'b0, head_q} + (lrkf_pkg::IDX_W + 1)'(count_q);
		if (slot_sum >= (lrkf_pkg::IDX_W + 1)'(lrkf_pkg::RING_DEPTH)) begin
			slot = lrkf_pkg::IDX_W'(slot_sum - (lrkf_pkg::IDX_W + 1)'(lrkf_pkg::RING_DEPTH));
		end else begin
			slot = slot_sum[lrkf_pkg::IDX_W-1:0];
		end
		if (head_q == lrkf_pkg::IDX_W'(lrkf_pkg::RING_DEPTH - 1)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + 1'b1;
		end
	end

	// oldest entry comes from the RAM the cycle after an advance
	assign eff_head = hv_ram_q ? rdata : head_val_q;
	assign do_push  = cmd.push && cmd.opp;
	assign pop      = do_push && (count_q == cmd.limit);
	assign pop_val  = (count_q == '0) ? cmd.pos : eff_head;

	// window start and length after this symbol
	always_comb begin
		if (pop) begin
			start_d = lrkf_pkg::LEN_W'(pop_val) + 1'b1;
		end else begin
			start_d = start_q;
		end
		win_len = lrkf_pkg::LEN_W'(cmd.pos) + 1'b1 - start_d;
	end

	lrkf_ram #(
		.WIDTH(lrkf_pkg::POS_W),
		.DEPTH(lrkf_pkg::RING_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (do_push),
		.waddr(slot),
		.wdata(cmd.pos),
		.raddr(head_inc),
		.rdata(rdata)
	);

	// ring pointers, window start and cached oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			start_q    <= '0;
			head_val_q <= '0;
			hv_ram_q   <= 1'b0;
		end else if (cmd.clr) begin
			head_q   <= '0;
			count_q  <= '0;
			start_q  <= '0;
			hv_ram_q <= 1'b0;
		end else if (pop) begin
			start_q <= start_d;
			head_q  <= head_inc;
			if (count_q == lrkf_pkg::CNT_W'(1)) begin
				// new oldest entry is the one written now
				head_val_q <= cmd.pos;
				hv_ram_q   <= 1'b0;
			end else if (count_q != '0) begin
				hv_ram_q <= 1'b1;
			end
		end else if (do_push) begin
			count_q <= count_q + 1'b1;
			if (count_q == '0) begin
				head_val_q <= cmd.pos;
				hv_ram_q   <= 1'b0;
			end else if (hv_ram_q) begin
				head_val_q <= rdata;
				hv_ram_q   <= 1'b0;
			end
		end else if (hv_ram_q) begin
			head_val_q <= rdata;
			hv_ram_q   <= 1'b0;
		end
	end

endmodule

// ===== hdl/longest_run_with_k_flips_unit.sv =====
// Longest uniform run reachable with at most max_changes symbol flips (capped at 1024).
// m_tvalid is registered. Throughput: one word per cycle while no marked word
// waits on an untaken result; each symbol does at most one push and one pop per
// ring, and the ring RAMs have one write and one registered read port.
// Reset clears control state at once; ring RAMs are not cleared, no sweep.
// Depends on lrkf_pkg, lrkf_track, lrkf_ram and the defines header.
`include "longest_run_with_k_flips_unit_defines.svh"

module longest_run_with_k_flips_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration write channel
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [lrkf_pkg::CFG_W-1:0] cfg_data,    // max_changes
	// input stream
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [lrkf_pkg::IN_W-1:0]  s_tdata,     // [0] symbol, rest zero
	input  logic                       s_tlast,     // last_symbol
	// result stream
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [lrkf_pkg::OUT_W-1:0] m_tdata      // [20:0] longest_run, rest zero
);

	logic [lrkf_pkg::CFG_W-1:0] cfg_q;
	logic [lrkf_pkg::CNT_W-1:0] limit_q;
	logic [lrkf_pkg::CNT_W-1:0] limit_sat;
	logic [lrkf_pkg::CNT_W-1:0] k_cur;
	logic [lrkf_pkg::LEN_W-1:0] pc_q;
	logic [lrkf_pkg::LEN_W-1:0] best_q;
	logic [lrkf_pkg::LEN_W-1:0] best_d;
	logic [lrkf_pkg::LEN_W-1:0] len_a;
	logic [lrkf_pkg::LEN_W-1:0] len_b;
	logic [lrkf_pkg::LEN_W-1:0] out_len_q;
	logic                       s1_valid;
	logic                       s1_symbol;
	logic                       s1_last;
	logic                       s1_adv;
	logic                       in_range;
	logic                       out_valid_q;
	lrkf_pkg::trk_cmd_t         cmd_a;
	lrkf_pkg::trk_cmd_t         cmd_b;

	assign cfg_ready = 1'b1;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	// input register stage
	assign s1_adv   = s1_valid && !(s1_last && out_valid_q && !m_tready);
	assign s_tready = !s1_valid || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_tready) begin
			s1_valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			s1_symbol <= s_tdata[0];
			s1_last   <= s_tlast;
		end
	end

	// change limit, latched at the first symbol of a string
	always_comb begin
		if (cfg_q > lrkf_pkg::CFG_W'(lrkf_pkg::CHANGE_LIMIT)) begin
			limit_sat = lrkf_pkg::CNT_W'(lrkf_pkg::CHANGE_LIMIT);
		end else begin
			limit_sat = lrkf_pkg::CNT_W'(cfg_q);
		end
		k_cur = (pc_q == '0) ? limit_sat : limit_q;
	end

	assign in_range = pc_q < lrkf_pkg::MAX_SYMBOLS;

	// tracker commands, one per target letter
	always_comb begin
		cmd_a.push  = s1_adv && in_range;
		cmd_a.opp   = s1_symbol;
		cmd_a.clr   = s1_adv && s1_last;
		cmd_a.limit = k_cur;
		cmd_a.pos   = pc_q[lrkf_pkg::POS_W-1:0];
		cmd_b       = cmd_a;
		cmd_b.opp   = !s1_symbol;
	end

	lrkf_track u_track_a (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_a),
		.win_len(len_a)
	);

	lrkf_track u_track_b (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_b),
		.win_len(len_b)
	);

	// best length over both targets
	always_comb begin
		best_d = best_q;
		if (in_range) begin
			if (len_a > best_d) begin
				best_d = len_a;
			end
			if (len_b > best_d) begin
				best_d = len_b;
			end
		end
	end

	// string counters and limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			best_q  <= '0;
			limit_q <= '0;
		end else if (s1_adv) begin
			limit_q <= k_cur;
			if (s1_last) begin
				pc_q   <= '0;
				best_q <= '0;
			end else begin
				best_q <= best_d;
				if (in_range) begin
					pc_q <= pc_q + 1'b1;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && s1_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_last) begin
			out_len_q <= best_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = lrkf_pkg::OUT_W'(out_len_q);

	// checks
	`LRKF_ASSERT_ALWAYS(a_best_le_count, best_q <= pc_q)
	`LRKF_ASSERT_NEXT(a_clear_after_last, s1_adv && s1_last, pc_q == '0 && best_q == '0)
	`LRKF_ASSERT_ALWAYS(a_stall_only_on_full, s_tready || (out_valid_q && !m_tready))

endmodule
